>>> rtl/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list
// Field widths, operation and status codes, and the control word that the
// list controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package bol_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_END   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INS_KEY   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEL_END   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // update command seen by every cell, op bits set only when list changes
    typedef struct packed {
        logic ins_front;
        logic ins_end;
        logic ins_key;
        logic key_found;
        logic del_front;
    } t_cell_ctrl;

endpackage

>>> rtl/bol_cell.sv
// ----------------------------------------------------------------------------
// bol_cell: one position of the list
// Holds one element, compares it against the search key and takes its new
// value from itself, its left or right neighbour, or the inserted value.
// ----------------------------------------------------------------------------
module bol_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 5
) (
    input  logic                        i_clk,
    input  bol_pkg::t_cell_ctrl         i_ctrl,
    input  logic [FILL_W-1:0]           i_fill,
    input  logic [bol_pkg::DATA_W-1:0]  i_value,
    input  logic [bol_pkg::DATA_W-1:0]  i_key,
    input  logic [bol_pkg::DATA_W-1:0]  i_left_data,
    input  logic [bol_pkg::DATA_W-1:0]  i_right_data,
    input  logic                        i_left_seen,
    input  logic                        i_left_seen_prev,
    output logic [bol_pkg::DATA_W-1:0]  o_data,
    output logic                        o_seen
);
    import bol_pkg::*;

    localparam logic [FILL_W-1:0] IDX_V = FILL_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_valid;
    logic              w_match;
    logic              w_at_end;

    // key compare, ripples a found flag to the right
    assign w_valid  = IDX_V < i_fill;
    assign w_match  = w_valid && (r_data == i_key);
    assign w_at_end = IDX_V == i_fill;
    assign o_seen   = i_left_seen | w_match;
    assign o_data   = r_data;

    // next element
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins_front) begin
            n_data = (IDX == 0) ? i_value : i_left_data;
        end else if (i_ctrl.ins_end || (i_ctrl.ins_key && !i_ctrl.key_found)) begin
            if (w_at_end) begin
                n_data = i_value;
            end
        end else if (i_ctrl.ins_key) begin
            // cells past the first match move right, the one just after it loads
            if (i_left_seen_prev) begin
                n_data = i_left_data;
            end else if (i_left_seen) begin
                n_data = i_value;
            end
        end else if (i_ctrl.del_front) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

>>> rtl/bounded_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit: ordered list of signed 32-bit values
// Chain of CAPACITY cells with a small controller and a registered output.
// ----------------------------------------------------------------------------
// Every operation but a read-out is done in its accepting cycle: all cells
// compare against the key and shift in parallel, and the single result goes
// to the output register, so such items can follow each other on every cycle
// while the output side keeps up. A read-out of a list of n elements gives n
// results, one per cycle through the output register after the accepting
// cycle while the output side keeps up, and no new item is accepted until the
// cycle after the last of them has been loaded. Inserts on a full list are
// dropped with status full; deletes and read-outs on an empty list report
// status empty. The reported count is the fill level in its low 5 bits.
module bounded_ordered_list_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // value [31:0], key [63:32]
    input  logic [2:0]  i_s_tuser,   // func [2:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // item [31:0], count [36:32], zero [39:37]
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser    // status [1:0]
);
    import bol_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam logic [FILL_W-1:0] CAP_V = FILL_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_m_valid, n_m_valid;
    logic [DATA_W-1:0]   r_item, n_item;
    logic                r_last, n_last;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic [FUNC_W-1:0]   w_func;
    logic [DATA_W-1:0]   w_value;
    logic [DATA_W-1:0]   w_key;
    logic                w_accept;
    logic                w_out_free;
    logic                w_full;
    logic                w_empty;
    logic                w_rd_last;
    t_cell_ctrl          w_ctrl;
    logic [DATA_W-1:0]   w_data [CAPACITY];
    logic                w_seen [CAPACITY+1];

    assign w_func  = i_s_tuser;
    assign w_value = i_s_tdata[31:0];
    assign w_key   = i_s_tdata[63:32];

    // handshake
    assign w_out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = r_fill == CAP_V;
    assign w_empty    = r_fill == '0;
    assign w_rd_last  = (FILL_W'(r_rd_idx) + FILL_W'(1)) == r_fill;

    // command to the cells
    always_comb begin
        w_ctrl           = '0;
        w_ctrl.key_found = w_seen[CAPACITY];
        if (w_accept) begin
            w_ctrl.ins_front = (w_func == FUNC_INS_FRONT) && !w_full;
            w_ctrl.ins_end   = (w_func == FUNC_INS_END) && !w_full;
            w_ctrl.ins_key   = (w_func == FUNC_INS_KEY) && !w_full;
            w_ctrl.del_front = (w_func == FUNC_DEL_FRONT) && !w_empty;
        end
    end

    // cell chain
    assign w_seen[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        logic              w_seen_prev;
        if (g == 0) begin : g_first
            assign w_left      = w_value;
            assign w_seen_prev = 1'b0;
        end else begin : g_inner
            assign w_left      = w_data[g-1];
            assign w_seen_prev = w_seen[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_data[g];
        end else begin : g_body
            assign w_right = w_data[g+1];
        end
        bol_cell #(
            .IDX    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk            (i_clk),
            .i_ctrl           (w_ctrl),
            .i_fill           (r_fill),
            .i_value          (w_value),
            .i_key            (w_key),
            .i_left_data      (w_left),
            .i_right_data     (w_right),
            .i_left_seen      (w_seen[g]),
            .i_left_seen_prev (w_seen_prev),
            .o_data           (w_data[g]),
            .o_seen           (w_seen[g+1])
        );
    end

    // controller and output register
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_rd_idx  = r_rd_idx;
        n_m_valid = r_m_valid && !i_m_tready;
        n_item    = r_item;
        n_last    = r_last;
        n_status  = r_status;
        n_count   = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = STATUS_OK;
                    unique case (w_func)
                        FUNC_INS_FRONT, FUNC_INS_END, FUNC_INS_KEY: begin
                            if (w_full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_fill = r_fill + FILL_W'(1);
                            end
                        end
                        FUNC_DEL_FRONT, FUNC_DEL_END: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_fill = r_fill - FILL_W'(1);
                            end
                        end
                        FUNC_READ: begin
                            if (w_empty) begin
                                n_status = STATUS_EMPTY;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                    if ((w_func == FUNC_READ) && !w_empty) begin
                        n_state  = S_READ;
                        n_rd_idx = '0;
                    end else begin
                        n_m_valid = 1'b1;
                        n_item    = '0;
                        n_last    = 1'b1;
                        n_count   = COUNT_W'(n_fill);
                    end
                end
            end
            S_READ: begin
                // one element per transfer, front first
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_item    = w_data[r_rd_idx];
                    n_last    = w_rd_last;
                    n_status  = STATUS_OK;
                    n_count   = COUNT_W'(r_fill);
                    n_rd_idx  = r_rd_idx + IDX_W'(1);
                    if (w_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rd_idx  <= n_rd_idx;
            r_m_valid <= n_m_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_last   <= n_last;
        r_status <= n_status;
        r_count  <= n_count;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_count, r_item};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_status;

endmodule
